/* rtl/ofz_pkg.sv */
// Package: shared constants for the order finding factorizer.
package ofz_pkg;
  localparam int NUM_WIDTH_DEF = 16;
  localparam int FIRST_BASE    = 2;
  localparam int BASE_COUNT    = 8;
endpackage

/* rtl/ofz_div.sv */
// Module: restoring divider, one quotient bit per cycle, shared by all modular steps.
module ofz_div #(
  parameter int NUM_WIDTH = ofz_pkg::NUM_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     go,
  input  logic [2*NUM_WIDTH-1:0]   dividend,
  input  logic [NUM_WIDTH-1:0]     divisor,
  output logic [2*NUM_WIDTH-1:0]   quot,
  output logic [NUM_WIDTH-1:0]     rem,
  output logic                     done
);
  import ofz_pkg::*;

  localparam int DW = 2 * NUM_WIDTH;
  localparam int CW = $clog2(DW) + 1;

  logic [NUM_WIDTH-1:0] dvs;
  logic [CW-1:0]        cnt;
  logic                 run;
  logic [NUM_WIDTH:0]   sh;
  logic                 fits;

  assign sh   = {rem, quot[DW-1]};
  assign fits = sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        cnt  <= '0;
        quot <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (run) begin
        // Shift one dividend bit into the partial remainder and subtract if it fits.
        quot <= {quot[DW-2:0], fits};
        rem  <= fits ? NUM_WIDTH'(sh - {1'b0, dvs}) : sh[NUM_WIDTH-1:0];
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(DW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

/* rtl/order_finding_factorizer.sv */
// Module: top level of the order finding factorizer.
// One item is a target N, taken when start is high and busy is low. The block
// tries bases 2 to 9: a base sharing a divisor with N returns that gcd and the
// cofactor; otherwise the multiplicative order r of the base is found by
// repeated modular multiplication (capped at N), and for even r the value
// x = base^(r/2) mod N is built by square and multiply and gcd(x-1,N) and
// gcd(x+1,N) are tried. Failure returns 1 and N. Every modulo, gcd step and
// final division goes through one shared restoring divider, started from a
// dispatch state; for each modular multiplication the product is first
// registered as the dividend. The time for an item is data dependent: short
// when a small base divides N, longest in a full order search. busy stays high
// for the whole item. The result appears on factor_one and factor_two for
// exactly one cycle with valid high; the receiver cannot stall it, so it
// must take the result in that cycle.
module order_finding_factorizer #(
  parameter int NUM_WIDTH = ofz_pkg::NUM_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [NUM_WIDTH-1:0] target,
  output logic                 valid,
  output logic [NUM_WIDTH-1:0] factor_one,
  output logic [NUM_WIDTH-1:0] factor_two
);
  import ofz_pkg::*;

  localparam int W  = NUM_WIDTH;
  localparam int KW = $clog2(BASE_COUNT);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_BASE  = 9'b000000010,
    S_GCD   = 9'b000000100,
    S_DIVGO = 9'b000001000,
    S_DIVW  = 9'b000010000,
    S_ORD   = 9'b000100000,
    S_MUL   = 9'b001000000,
    S_POW   = 9'b010000000,
    S_NEXT  = 9'b100000000
  } state_t;

  // What the pending division result is for.
  typedef enum logic [2:0] {K_GCD, K_VINIT, K_MUL, K_PBASE, K_FIN} dkind_t;
  // Which gcd is running.
  typedef enum logic [1:0] {G_BASE, G_LO, G_HI} gctx_t;
  // Which modular product is running.
  typedef enum logic [1:0] {M_ORD, M_PR, M_PB} mctx_t;

  state_t state;
  dkind_t dkind;
  gctx_t  gctx;
  mctx_t  mctx;

  logic [W-1:0]   n, a, ga, gb, v, p, e, r, pbase, x, fval;
  logic [KW-1:0]  k;
  logic           fswap;
  logic [2*W-1:0] dvd;
  logic [W-1:0]   dvs;
  logic [2*W-1:0] quot;
  logic [W-1:0]   rem;
  logic           div_done;
  logic [W-1:0]   opa, opb;
  logic [W-1:0]   lo;

  ofz_div #(.NUM_WIDTH(NUM_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (state == S_DIVGO),
    .dividend (dvd),
    .divisor  (dvs),
    .quot     (quot),
    .rem      (rem),
    .done     (div_done)
  );

  assign busy = (state != S_IDLE);
  // gcd(x-1,N) is taken as 1 when x is zero.
  assign lo   = (x == '0) ? W'(1) : ga;

  always_comb begin
    unique case (mctx)
      M_ORD:   begin opa = v;     opb = a;     end
      M_PR:    begin opa = r;     opb = pbase; end
      default: begin opa = pbase; opb = pbase; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            n     <= target;
            a     <= W'(FIRST_BASE);
            k     <= '0;
            state <= S_BASE;
          end
        end
        S_BASE: begin
          ga    <= a;
          gb    <= n;
          gctx  <= G_BASE;
          state <= S_GCD;
        end
        S_GCD: begin
          if (gb != '0) begin
            dvd   <= {{W{1'b0}}, ga};
            dvs   <= gb;
            dkind <= K_GCD;
            state <= S_DIVGO;
          end else begin
            unique case (gctx)
              G_BASE: begin
                if (ga > W'(1)) begin
                  fval  <= ga;
                  fswap <= 1'b0;
                  dvd   <= {{W{1'b0}}, n};
                  dvs   <= ga;
                  dkind <= K_FIN;
                end else begin
                  dvd   <= {{W{1'b0}}, a};
                  dvs   <= n;
                  dkind <= K_VINIT;
                end
                state <= S_DIVGO;
              end
              G_LO: begin
                if (lo > W'(1) && lo < n) begin
                  fval  <= lo;
                  fswap <= 1'b0;
                  dvd   <= {{W{1'b0}}, n};
                  dvs   <= lo;
                  dkind <= K_FIN;
                  state <= S_DIVGO;
                end else begin
                  ga    <= x + W'(1);
                  gb    <= n;
                  gctx  <= G_HI;
                  state <= S_GCD;
                end
              end
              default: begin
                if (ga > W'(1) && ga < n) begin
                  fval  <= ga;
                  fswap <= 1'b1;
                  dvd   <= {{W{1'b0}}, n};
                  dvs   <= ga;
                  dkind <= K_FIN;
                  state <= S_DIVGO;
                end else begin
                  state <= S_NEXT;
                end
              end
            endcase
          end
        end
        S_DIVGO: state <= S_DIVW;
        S_DIVW: begin
          if (div_done) begin
            unique case (dkind)
              K_GCD: begin
                ga    <= gb;
                gb    <= rem;
                state <= S_GCD;
              end
              K_VINIT: begin
                v     <= rem;
                p     <= W'(1);
                state <= S_ORD;
              end
              K_MUL: begin
                unique case (mctx)
                  M_ORD: begin
                    v     <= rem;
                    p     <= p + W'(1);
                    state <= S_ORD;
                  end
                  M_PR: begin
                    r     <= rem;
                    mctx  <= M_PB;
                    state <= S_MUL;
                  end
                  default: begin
                    pbase <= rem;
                    e     <= e >> 1;
                    state <= S_POW;
                  end
                endcase
              end
              K_PBASE: begin
                pbase <= rem;
                state <= S_POW;
              end
              default: begin
                // The quotient never exceeds N, so it fits the field.
                factor_one <= fswap ? quot[W-1:0] : fval;
                factor_two <= fswap ? fval : quot[W-1:0];
                valid      <= 1'b1;
                state      <= S_IDLE;
              end
            endcase
          end
        end
        S_ORD: begin
          // Order search stops when the power returns to one or the count reaches N.
          if (v != W'(1) && p < n) begin
            mctx  <= M_ORD;
            state <= S_MUL;
          end else if (!p[0]) begin
            e     <= p >> 1;
            r     <= (n == W'(1)) ? '0 : W'(1);
            dvd   <= {{W{1'b0}}, a};
            dvs   <= n;
            dkind <= K_PBASE;
            state <= S_DIVGO;
          end else begin
            state <= S_NEXT;
          end
        end
        S_MUL: begin
          dvd   <= opa * opb;
          dvs   <= n;
          dkind <= K_MUL;
          state <= S_DIVGO;
        end
        S_POW: begin
          if (e == '0) begin
            x     <= r;
            ga    <= (r == '0) ? W'(1) : r - W'(1);
            gb    <= n;
            gctx  <= G_LO;
            state <= S_GCD;
          end else begin
            mctx  <= e[0] ? M_PR : M_PB;
            state <= S_MUL;
          end
        end
        default: begin
          if (k == KW'(BASE_COUNT - 1)) begin
            factor_one <= W'(1);
            factor_two <= n;
            valid      <= 1'b1;
            state      <= S_IDLE;
          end else begin
            k     <= k + 1'b1;
            a     <= a + W'(1);
            state <= S_BASE;
          end
        end
      endcase
    end
  end
endmodule

/* tb/tb_order_finding_factorizer.sv */
// Testbench for the order finding factorizer: directed and random targets checked against a predictor.
module tb_order_finding_factorizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = ofz_pkg::NUM_WIDTH_DEF;
  // Generous ceiling; a correct run with the chosen targets needs far fewer cycles.
  localparam longint CYCLE_LIMIT = 60_000_000;
  // Marker in the pending queue: the driver holds off until every expected result is in.
  localparam int DRAIN_MARK = -1;

  logic         clk;
  logic         rst;
  logic         start;
  logic         busy;
  logic [W-1:0] target;
  logic         valid;
  logic [W-1:0] factor_one;
  logic [W-1:0] factor_two;

  typedef struct packed {
    logic [W-1:0] one;
    logic [W-1:0] two;
  } factor_pair_t;

  int           pending_targets[$];
  factor_pair_t expected_pairs[$];
  int           gap_left;
  int           mismatches;
  int           items_sent;
  int           results_seen;
  longint       cycles;
  logic         taken;

  order_finding_factorizer u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .target(target),
    .valid(valid), .factor_one(factor_one), .factor_two(factor_two)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic longint unsigned gcd_of(longint unsigned a, longint unsigned b);
    longint unsigned t;
    while (b != 0) begin
      t = b;
      b = a % b;
      a = t;
    end
    return a;
  endfunction

  // Predicts the factor pair: bases 2 to 9, gcd check first, then an order search
  // capped at N, and for an even order the two gcds around base^(order/2).
  function automatic factor_pair_t predict_factors(logic [W-1:0] n_in);
    longint unsigned n, a, g, p, v, x, b, e, lo, hi;
    factor_pair_t    res;
    n = n_in;
    res.one = 1;
    res.two = n_in;
    for (int k = 0; k < ofz_pkg::BASE_COUNT; k++) begin
      a = ofz_pkg::FIRST_BASE + k;
      g = gcd_of(a, n);
      if (g > 1) begin
        res.one = W'(g);
        res.two = W'(n / g);
        return res;
      end
      // Here n is at least one, since a zero target always takes the branch above.
      p = 1;
      v = a % n;
      while (v != 1 && p < n) begin
        v = (v * a) % n;
        p++;
      end
      if (p[0] == 1'b0) begin
        x = 1 % n;
        b = a % n;
        e = p / 2;
        while (e > 0) begin
          if (e[0]) x = (x * b) % n;
          e = e >> 1;
          b = (b * b) % n;
        end
        lo = (x == 0) ? 1 : gcd_of(x - 1, n);
        hi = gcd_of(x + 1, n);
        if (lo > 1 && lo < n) begin
          res.one = W'(lo);
          res.two = W'(n / lo);
          return res;
        end
        if (hi > 1 && hi < n) begin
          res.two = W'(hi);
          res.one = W'(n / hi);
          return res;
        end
      end
    end
    return res;
  endfunction

  // Back-to-back or a short gap about equally often, now and then a long one.
  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 80);
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    mismatches++;
  endtask

  // Driver. An item is taken at an edge where start is high and busy is low;
  // start is written once per edge so it can stay high across items.
  always @(posedge clk) begin
    if (rst) begin
      start    <= 1'b0;
      target   <= '0;
      gap_left <= 0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_pairs.push_back(predict_factors(target));
        items_sent++;
      end
      if (start && !taken) begin
        // Hold the item until the block takes it.
      end else if (gap_left > 0) begin
        start    <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_targets.size() > 0 && pending_targets[0] == DRAIN_MARK) begin
        start <= 1'b0;
        if (expected_pairs.size() == 0 && !busy && !taken) void'(pending_targets.pop_front());
      end else if (pending_targets.size() > 0) begin
        target   <= W'(pending_targets.pop_front());
        start    <= 1'b1;
        gap_left <= next_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor. A result is present for one cycle only, so it is taken whenever valid is high.
  always @(posedge clk) begin
    if (!rst && valid) begin
      if (expected_pairs.size() == 0) begin
        $display("unexpected result at cycle %0d: %0d x %0d", cycles, factor_one, factor_two);
        mismatches++;
      end else begin
        if (factor_one !== expected_pairs[0].one)
          report_mismatch("factor_one", factor_one, expected_pairs[0].one);
        if (factor_two !== expected_pairs[0].two)
          report_mismatch("factor_two", factor_two, expected_pairs[0].two);
        void'(expected_pairs.pop_front());
      end
      results_seen++;
    end
  end

  // Watchdog on the total number of cycles.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int pick;
    int k;
    rst          = 1'b1;
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    cycles       = 0;

    // Directed targets: zero and one, small primes where a base exceeds the
    // target, field extremes, products of primes, most of them above nine, where
    // the order search and the gcd step decide, and a prime whose order is odd.
    pending_targets = '{0, 1, 2, 3, 5, 7, 11, 13, 15, 21, 23, 77, 91, 121, 143,
                        169, 187, 221, 65535, 65534, 32768, 43690, 21845, 49151};
    pending_targets.push_back(DRAIN_MARK);

    // Random part. Large targets are even, with a second small factor mixed in,
    // so base two settles them at once while every bit still toggles; small
    // targets, some coprime to the bases, exercise the order search and the trivial gcd rejection.
    for (int i = 0; i < 76; i++) begin
      if (i == 38) pending_targets.push_back(DRAIN_MARK);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        case ($urandom_range(0, 3))
          0: k = 2;
          1: k = 3;
          2: k = 5;
          default: k = 7;
        endcase
        pending_targets.push_back(2 * k * $urandom_range(1, 65535 / (2 * k)));
      end else if (pick < 95) begin
        pending_targets.push_back($urandom_range(11, 127));
      end else begin
        pending_targets.push_back($urandom_range(0, 10));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (pending_targets.size() == 0 && !start && expected_pairs.size() == 0);
    repeat (100) @(posedge clk);

    $display("Covered %0d targets (zero, one, small primes, field extremes, coprime products)",
             items_sent);
    $display("with random gaps and two full drains; %0d results checked, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && expected_pairs.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
